### src/odf_pkg.sv
package odf_pkg;

  localparam int unsigned DIST_W     = 10;
  localparam int unsigned SPEED_W    = 7;
  localparam int unsigned CMD_W      = 8;
  localparam int unsigned LINE_W     = 3;
  localparam int unsigned TICK_W     = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [TICK_W-1:0]  HOLD_TICKS = TICK_W'(200);
  localparam logic [TICK_W-1:0]  TURN_TICKS = TICK_W'(300);
  localparam logic [SPEED_W-1:0] SPEED_MAX  = SPEED_W'(100);

  typedef enum logic [1:0] {
    MODE_RUN  = 2'd0,
    MODE_SLOW = 2'd1,
    MODE_BACK = 2'd2,
    MODE_TURN = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    MOT_NONE = 3'd0,
    MOT_FWD  = 3'd1,
    MOT_BACK = 3'd2,
    MOT_STOP = 3'd3,
    MOT_CW   = 3'd4,
    MOT_CCW  = 3'd5,
    MOT_LINE = 3'd6,
    MOT_CMD  = 3'd7
  } motion_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DANGER_CM    = 4'd0,
    CFG_BACK_CM      = 4'd1,
    CFG_SLOW_CM      = 4'd2,
    CFG_SAFE_CM      = 4'd3,
    CFG_CRUISE_SPEED = 4'd4,
    CFG_SLOW_SPEED   = 4'd5,
    CFG_BACK_SPEED   = 4'd6,
    CFG_TURN_SPEED   = 4'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [DIST_W-1:0]  danger_cm;
    logic [DIST_W-1:0]  back_cm;
    logic [DIST_W-1:0]  slow_cm;
    logic [DIST_W-1:0]  safe_cm;
    logic [SPEED_W-1:0] cruise_speed;
    logic [SPEED_W-1:0] slow_speed;
    logic [SPEED_W-1:0] back_speed;
    logic [SPEED_W-1:0] turn_speed;
  } cfg_t;

  // Clamp a speed register to 100 percent.
  function automatic logic [SPEED_W-1:0] sat_speed(input logic [SPEED_W-1:0] s);
    return (s > SPEED_MAX) ? SPEED_MAX : s;
  endfunction

endpackage

### src/odf_if.sv
interface odf_in_if;
  logic                         valid;
  logic                         ready;
  logic                         command_valid;
  logic [odf_pkg::CMD_W-1:0]    command;
  logic [odf_pkg::DIST_W-1:0]   distance_cm;
  logic [odf_pkg::LINE_W-1:0]   line_bits;
  logic [odf_pkg::TICK_W-1:0]   now_tick;

  modport source (output valid, command_valid, command, distance_cm, line_bits, now_tick,
                  input ready);
  modport sink (input valid, command_valid, command, distance_cm, line_bits, now_tick,
                output ready);
endinterface

interface odf_out_if;
  logic                         valid;
  logic                         ready;
  logic [2:0]                   motion;
  logic [odf_pkg::SPEED_W-1:0]  speed;
  logic                         speed_set;
  logic [odf_pkg::LINE_W-1:0]   line_out;
  logic [odf_pkg::CMD_W-1:0]    command_out;
  logic [1:0]                   mode_out;

  modport source (output valid, motion, speed, speed_set, line_out, command_out, mode_out,
                  input ready);
  modport sink (input valid, motion, speed, speed_set, line_out, command_out, mode_out,
                output ready);
endinterface

interface odf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [odf_pkg::CFG_IDX_W-1:0]   index;
  logic [odf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/odf_cfg_regs.sv
module odf_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  odf_cfg_if.sink       cfg_i,
  output odf_pkg::cfg_t cfg_o
);

  odf_pkg::cfg_t cfg_q, cfg_d;
  logic          wr;

  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid & cfg_i.ready;

  // Keep the low bits of the data; drop writes beyond the register list.
  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (cfg_i.index)
        odf_pkg::CFG_DANGER_CM:    cfg_d.danger_cm    = cfg_i.data[odf_pkg::DIST_W-1:0];
        odf_pkg::CFG_BACK_CM:      cfg_d.back_cm      = cfg_i.data[odf_pkg::DIST_W-1:0];
        odf_pkg::CFG_SLOW_CM:      cfg_d.slow_cm      = cfg_i.data[odf_pkg::DIST_W-1:0];
        odf_pkg::CFG_SAFE_CM:      cfg_d.safe_cm      = cfg_i.data[odf_pkg::DIST_W-1:0];
        odf_pkg::CFG_CRUISE_SPEED: cfg_d.cruise_speed = cfg_i.data[odf_pkg::SPEED_W-1:0];
        odf_pkg::CFG_SLOW_SPEED:   cfg_d.slow_speed   = cfg_i.data[odf_pkg::SPEED_W-1:0];
        odf_pkg::CFG_BACK_SPEED:   cfg_d.back_speed   = cfg_i.data[odf_pkg::SPEED_W-1:0];
        odf_pkg::CFG_TURN_SPEED:   cfg_d.turn_speed   = cfg_i.data[odf_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.danger_cm    <= odf_pkg::DIST_W'(5);
      cfg_q.back_cm      <= odf_pkg::DIST_W'(7);
      cfg_q.slow_cm      <= odf_pkg::DIST_W'(15);
      cfg_q.safe_cm      <= odf_pkg::DIST_W'(30);
      cfg_q.cruise_speed <= odf_pkg::SPEED_W'(70);
      cfg_q.slow_speed   <= odf_pkg::SPEED_W'(40);
      cfg_q.back_speed   <= odf_pkg::SPEED_W'(50);
      cfg_q.turn_speed   <= odf_pkg::SPEED_W'(60);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### src/obstacle_avoid_drive_fsm.sv
// Obstacle-avoiding drive controller.
// item_i carries one control tick: an optional remote command, the ultrasonic
// distance, the three line-sensor bits and the free-running tick time.
// result_o returns exactly one item per tick: motion code, speed with its
// set flag, line bits for the line follower, command code for the command
// interpreter, and the drive mode left after the tick.
// cfg_i writes the four distance thresholds and four speed registers
// (index 0..7); other indexes are accepted and dropped. Write only while idle.
// An accepted item lands in the input register, then its result moves into
// the result register once that is free, which drives result_o.
// Throughput: one item per cycle while result_o is not stalled; the mode,
// entry time and turn direction update at the same edge that loads the
// result register, so the next item in the input register already sees the
// new state.
// Reset clears mode to run, entry time and turn direction to zero, loads the
// register defaults and empties both pipeline registers.
// When the receiver stalls, the result register holds and the input register
// holds once it is full; item_i.ready drops only when both are occupied and
// result_o.ready is low.
module obstacle_avoid_drive_fsm (
  input  logic      clk_i,
  input  logic      rst_ni,
  odf_in_if.sink    item_i,
  odf_out_if.source result_o,
  odf_cfg_if.sink   cfg_i
);

  odf_pkg::cfg_t cfg;

  odf_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Input register.
  logic                         in_vld_q;
  logic                         cmd_vld_q;
  logic [odf_pkg::CMD_W-1:0]    cmd_q;
  logic [odf_pkg::DIST_W-1:0]   dist_q;
  logic [odf_pkg::LINE_W-1:0]   line_q;
  logic [odf_pkg::TICK_W-1:0]   now_q;

  // Result register.
  logic                         out_vld_q;
  odf_pkg::motion_e             motion_q, motion_d;
  logic [odf_pkg::SPEED_W-1:0]  speed_q, speed_d;
  logic                         sset_q, sset_d;
  logic [odf_pkg::LINE_W-1:0]   lout_q, lout_d;
  logic [odf_pkg::CMD_W-1:0]    cout_q, cout_d;

  // Controller state.
  odf_pkg::mode_e               mode_q, mode_d;
  logic [odf_pkg::TICK_W-1:0]   enter_q, enter_d;
  logic                         dir_q, dir_d;

  logic                         out_free;
  logic                         advance;
  logic                         take_in;
  logic [odf_pkg::TICK_W-1:0]   elapsed;
  logic                         hold_done;
  logic                         turn_due;

  // Advance the input register into the result register when the latter is
  // empty or being drained this cycle.
  assign out_free     = ~out_vld_q | result_o.ready;
  assign advance      = in_vld_q & out_free;
  assign item_i.ready = ~in_vld_q | out_free;
  assign take_in      = item_i.valid & item_i.ready;

  // Wrapping elapsed time since the last mode entry or turn pulse.
  assign elapsed   = now_q - enter_q;
  assign hold_done = elapsed >= odf_pkg::HOLD_TICKS;
  assign turn_due  = elapsed >= odf_pkg::TURN_TICKS;

  always_comb begin
    mode_d   = mode_q;
    enter_d  = enter_q;
    dir_d    = dir_q;
    motion_d = odf_pkg::MOT_NONE;
    speed_d  = '0;
    sset_d   = 1'b0;
    lout_d   = '0;
    cout_d   = '0;

    if (cmd_vld_q) begin
      // A remote command wins: pass it out and fall back to run mode.
      motion_d = odf_pkg::MOT_CMD;
      cout_d   = cmd_q;
      mode_d   = odf_pkg::MODE_RUN;
    end else begin
      unique case (mode_q)
        odf_pkg::MODE_RUN: begin
          if (dist_q < cfg.danger_cm) begin
            motion_d = odf_pkg::MOT_STOP;
            mode_d   = odf_pkg::MODE_TURN;
            enter_d  = now_q;
          end else if (dist_q < cfg.back_cm) begin
            motion_d = odf_pkg::MOT_BACK;
            speed_d  = odf_pkg::sat_speed(cfg.back_speed);
            sset_d   = 1'b1;
            mode_d   = odf_pkg::MODE_BACK;
            enter_d  = now_q;
          end else if (dist_q < cfg.slow_cm) begin
            motion_d = odf_pkg::MOT_FWD;
            speed_d  = odf_pkg::sat_speed(cfg.slow_speed);
            sset_d   = 1'b1;
            mode_d   = odf_pkg::MODE_SLOW;
            enter_d  = now_q;
          end else begin
            motion_d = odf_pkg::MOT_LINE;
            speed_d  = odf_pkg::sat_speed(cfg.cruise_speed);
            sset_d   = 1'b1;
            lout_d   = line_q;
          end
        end
        odf_pkg::MODE_SLOW: begin
          motion_d = odf_pkg::MOT_FWD;
          speed_d  = odf_pkg::sat_speed(cfg.slow_speed);
          sset_d   = 1'b1;
          if (dist_q >= cfg.slow_cm && hold_done) begin
            mode_d = odf_pkg::MODE_RUN;
          end else if (dist_q < cfg.back_cm) begin
            mode_d  = odf_pkg::MODE_BACK;
            enter_d = now_q;
          end
        end
        odf_pkg::MODE_BACK: begin
          motion_d = odf_pkg::MOT_BACK;
          speed_d  = odf_pkg::sat_speed(cfg.back_speed);
          sset_d   = 1'b1;
          if (dist_q >= cfg.back_cm && hold_done) begin
            mode_d  = odf_pkg::MODE_SLOW;
            enter_d = now_q;
          end else if (dist_q >= cfg.safe_cm) begin
            mode_d = odf_pkg::MODE_RUN;
          end
        end
        odf_pkg::MODE_TURN: begin
          // Flip rotation once per turn pulse; leave only when clearly free.
          if (turn_due) begin
            dir_d    = ~dir_q;
            motion_d = dir_d ? odf_pkg::MOT_CW : odf_pkg::MOT_CCW;
            speed_d  = odf_pkg::sat_speed(cfg.turn_speed);
            sset_d   = 1'b1;
            enter_d  = now_q;
            if (dist_q > cfg.safe_cm) begin
              mode_d = odf_pkg::MODE_RUN;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Control: pipeline valids and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mode_q    <= odf_pkg::MODE_RUN;
      enter_q   <= '0;
      dir_q     <= 1'b0;
    end else begin
      if (item_i.ready) begin
        in_vld_q <= item_i.valid;
      end
      if (out_free) begin
        out_vld_q <= in_vld_q;
      end
      if (advance) begin
        mode_q  <= mode_d;
        enter_q <= enter_d;
        dir_q   <= dir_d;
      end
    end
  end

  // Payload: input register loads on acceptance, result register on advance.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      cmd_vld_q <= item_i.command_valid;
      cmd_q     <= item_i.command;
      dist_q    <= item_i.distance_cm;
      line_q    <= item_i.line_bits;
      now_q     <= item_i.now_tick;
    end
    if (advance) begin
      motion_q <= motion_d;
      speed_q  <= speed_d;
      sset_q   <= sset_d;
      lout_q   <= lout_d;
      cout_q   <= cout_d;
    end
  end

  // The mode field of a result is the mode left by that item, which is the
  // state register right after it advanced; hold it alongside the result.
  logic [1:0] mode_out_q;
  always_ff @(posedge clk_i) begin
    if (advance) begin
      mode_out_q <= mode_d;
    end
  end

  assign result_o.valid       = out_vld_q;
  assign result_o.motion      = motion_q;
  assign result_o.speed       = speed_q;
  assign result_o.speed_set   = sset_q;
  assign result_o.line_out    = lout_q;
  assign result_o.command_out = cout_q;
  assign result_o.mode_out    = mode_out_q;

endmodule

### src/odf_checker.sv
module odf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [2:0]                  motion,
  input logic [odf_pkg::SPEED_W-1:0] speed,
  input logic                        speed_set,
  input logic [odf_pkg::LINE_W-1:0]  line_out,
  input logic [odf_pkg::CMD_W-1:0]   command_out,
  input logic [1:0]                  mode_out
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> $stable(motion) && $stable(speed) && $stable(speed_set)
      && $stable(line_out) && $stable(command_out) && $stable(mode_out))
    else $error("result payload changed while stalled");

  // A command tick never sets speed and always ends in run mode.
  a_cmd_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && motion == odf_pkg::MOT_CMD |-> !speed_set
      && mode_out == odf_pkg::MODE_RUN)
    else $error("command tick with speed or wrong mode");

  // Line and command fields are zero unless their motion selects them; a set speed never exceeds the maximum.
  a_side_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (motion == odf_pkg::MOT_LINE || line_out == '0)
      && (motion == odf_pkg::MOT_CMD || command_out == '0)
      && (!speed_set || speed <= odf_pkg::SPEED_MAX))
    else $error("stray line, command or speed value");

  // Idle and stop motions only come with turn mode; neither carries a speed.
  a_turn_motion: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && (motion == odf_pkg::MOT_NONE || motion == odf_pkg::MOT_STOP)
      |-> mode_out == odf_pkg::MODE_TURN && !speed_set)
    else $error("idle or stop motion outside turn mode");

endmodule

bind obstacle_avoid_drive_fsm odf_checker u_odf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (result_o.valid),
  .out_ready   (result_o.ready),
  .motion      (result_o.motion),
  .speed       (result_o.speed),
  .speed_set   (result_o.speed_set),
  .line_out    (result_o.line_out),
  .command_out (result_o.command_out),
  .mode_out    (result_o.mode_out)
);

### tb/tb_obstacle_avoid_drive_fsm.sv
`timescale 1ns / 1ps

module tb_obstacle_avoid_drive_fsm;
  import odf_pkg::*;

  localparam int unsigned LIMIT_COUNT   = int'(CFG_TURN_SPEED) + 1;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam int unsigned PHASE_ITEMS   = 85;
  localparam int unsigned SETTLE_CYCLES = 4;

  // One control tick as driven on item_i.
  typedef struct {
    bit                cmd_valid;
    bit [CMD_W-1:0]    cmd;
    bit [DIST_W-1:0]   dist_cm;
    bit [LINE_W-1:0]   line;
    bit [TICK_W-1:0]   stamp;
  } tick_t;

  // One drive decision as seen on result_o.
  typedef struct {
    motion_e            motion;
    logic [SPEED_W-1:0] speed;
    logic               speed_set;
    logic [LINE_W-1:0]  line_out;
    logic [CMD_W-1:0]   cmd_out;
    mode_e              mode;
  } drive_t;

  typedef enum int {
    LIM_ALL_LOW,
    LIM_ALL_HIGH,
    LIM_SCRAMBLED,
    LIM_ORDERED
  } limits_kind_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  odf_in_if  tick_if ();
  odf_out_if drive_if ();
  odf_cfg_if limit_if ();

  obstacle_avoid_drive_fsm DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (tick_if),
    .result_o (drive_if),
    .cfg_i    (limit_if)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the controller: thresholds, speeds, mode, entry time and turn direction.
  cfg_t               limits;
  mode_e              drive_mode;
  logic [TICK_W-1:0]  entered_at;
  logic               spin_cw;

  drive_t             pending_drive_q [$];
  tick_t              directed_q [$];
  bit                 typed_q [$];
  drive_t             typed_want_q [$];

  logic [TICK_W-1:0]  clock_now;
  int unsigned        gap_pct;
  int unsigned        stall_pct;
  bit                 calm;
  bit                 failed = 1'b0;

  function automatic logic [SPEED_W-1:0] pct_limit(input logic [SPEED_W-1:0] raw);
    pct_limit = raw;
    if (raw > SPEED_MAX) pct_limit = SPEED_MAX;
  endfunction

  // Advance the shadow by one tick and return the decision it implies.
  function automatic drive_t predict_drive(input tick_t t);
    drive_t             r;
    logic [TICK_W-1:0]  elapsed;
    elapsed     = t.stamp - entered_at;
    r.motion    = MOT_NONE;
    r.speed     = '0;
    r.speed_set = 1'b0;
    r.line_out  = '0;
    r.cmd_out   = '0;
    if (t.cmd_valid) begin
      // A remote command wins over everything and drops back to run mode.
      r.motion   = MOT_CMD;
      r.cmd_out  = t.cmd;
      drive_mode = MODE_RUN;
    end else begin
      case (drive_mode)
        MODE_RUN: begin
          if (t.dist_cm < limits.danger_cm) begin
            r.motion   = MOT_STOP;
            drive_mode = MODE_TURN;
            entered_at = t.stamp;
          end else if (t.dist_cm < limits.back_cm) begin
            r.motion    = MOT_BACK;
            r.speed     = pct_limit(limits.back_speed);
            r.speed_set = 1'b1;
            drive_mode  = MODE_BACK;
            entered_at  = t.stamp;
          end else if (t.dist_cm < limits.slow_cm) begin
            r.motion    = MOT_FWD;
            r.speed     = pct_limit(limits.slow_speed);
            r.speed_set = 1'b1;
            drive_mode  = MODE_SLOW;
            entered_at  = t.stamp;
          end else begin
            r.motion    = MOT_LINE;
            r.speed     = pct_limit(limits.cruise_speed);
            r.speed_set = 1'b1;
            r.line_out  = t.line;
          end
        end
        MODE_SLOW: begin
          r.motion    = MOT_FWD;
          r.speed     = pct_limit(limits.slow_speed);
          r.speed_set = 1'b1;
          if (t.dist_cm >= limits.slow_cm && elapsed >= HOLD_TICKS) begin
            drive_mode = MODE_RUN;
          end else if (t.dist_cm < limits.back_cm) begin
            drive_mode = MODE_BACK;
            entered_at = t.stamp;
          end
        end
        MODE_BACK: begin
          r.motion    = MOT_BACK;
          r.speed     = pct_limit(limits.back_speed);
          r.speed_set = 1'b1;
          if (t.dist_cm >= limits.back_cm && elapsed >= HOLD_TICKS) begin
            drive_mode = MODE_SLOW;
            entered_at = t.stamp;
          end else if (t.dist_cm >= limits.safe_cm) begin
            drive_mode = MODE_RUN;
          end
        end
        default: begin
          // Turn: rotate only once the pulse is due, flipping direction each time.
          if (elapsed >= TURN_TICKS) begin
            spin_cw     = ~spin_cw;
            r.motion    = spin_cw ? MOT_CW : MOT_CCW;
            r.speed     = pct_limit(limits.turn_speed);
            r.speed_set = 1'b1;
            entered_at  = t.stamp;
            if (t.dist_cm > limits.safe_cm) drive_mode = MODE_RUN;
          end
        end
      endcase
    end
    r.mode = drive_mode;
    return r;
  endfunction

  function automatic void add_tick(input bit cv, input bit [CMD_W-1:0] cmd,
                                   input bit [DIST_W-1:0] dist_cm,
                                   input bit [LINE_W-1:0] line,
                                   input bit [TICK_W-1:0] stamp);
    tick_t  t;
    drive_t none;
    t.cmd_valid = cv;
    t.cmd       = cmd;
    t.dist_cm   = dist_cm;
    t.line      = line;
    t.stamp     = stamp;
    none.motion = MOT_NONE;
    none.mode   = MODE_RUN;
    directed_q.push_back(t);
    typed_q.push_back(1'b0);
    typed_want_q.push_back(none);
  endfunction

  // Row whose outcome is plain from the reset limits; the typed value is checked.
  function automatic void add_typed(input bit cv, input bit [CMD_W-1:0] cmd,
                                    input bit [DIST_W-1:0] dist_cm,
                                    input bit [LINE_W-1:0] line,
                                    input bit [TICK_W-1:0] stamp, input motion_e motion,
                                    input bit [SPEED_W-1:0] speed, input bit speed_set,
                                    input bit [LINE_W-1:0] line_out,
                                    input bit [CMD_W-1:0] cmd_out, input mode_e mode);
    drive_t w;
    w.motion    = motion;
    w.speed     = speed;
    w.speed_set = speed_set;
    w.line_out  = line_out;
    w.cmd_out   = cmd_out;
    w.mode      = mode;
    add_tick(cv, cmd, dist_cm, line, stamp);
    typed_q[$]      = 1'b1;
    typed_want_q[$] = w;
  endfunction

  // Walk of the mode machine under the reset limits (5/7/15/30 cm, 70/40/50/60 %).
  function automatic void build_directed();
    add_typed(0, 8'h00, 10'd1023, 3'd7, 32'd0,   MOT_LINE, 7'd70, 1, 3'd7, 8'h00, MODE_RUN);
    add_typed(1, 8'hFF, 10'd0,    3'd7, 32'd1,   MOT_CMD,  7'd0,  0, 3'd0, 8'hFF, MODE_RUN);
    add_typed(1, 8'h00, 10'd1023, 3'd0, 32'd2,   MOT_CMD,  7'd0,  0, 3'd0, 8'h00, MODE_RUN);
    // Danger: stop, then wait out the turn pulse one tick short and exactly on time.
    add_typed(0, 8'h3C, 10'd0,    3'd2, 32'd10,  MOT_STOP, 7'd0,  0, 3'd0, 8'h00, MODE_TURN);
    add_typed(0, 8'h00, 10'd1023, 3'd1, 32'd309, MOT_NONE, 7'd0,  0, 3'd0, 8'h00, MODE_TURN);
    add_typed(0, 8'h00, 10'd30,   3'd1, 32'd310, MOT_CW,   7'd60, 1, 3'd0, 8'h00, MODE_TURN);
    add_typed(0, 8'h00, 10'd31,   3'd1, 32'd610, MOT_CCW,  7'd60, 1, 3'd0, 8'h00, MODE_RUN);
    // Back and slow with the hold time one short and exactly met.
    add_tick(0, 8'h00, 10'd5,  3'd0, 32'd700);
    add_tick(0, 8'h00, 10'd30, 3'd0, 32'd899);
    add_tick(0, 8'h00, 10'd14, 3'd0, 32'd900);
    add_tick(0, 8'h00, 10'd15, 3'd0, 32'd1099);
    add_tick(0, 8'h00, 10'd6,  3'd0, 32'd1099);
    add_tick(0, 8'h00, 10'd7,  3'd0, 32'd1299);
    add_tick(0, 8'h00, 10'd15, 3'd0, 32'd1499);
    // Hold time measured across the 32-bit wrap.
    add_tick(0, 8'h00, 10'd6,  3'd0, 32'hFFFF_FF9C);
    add_tick(0, 8'h00, 10'd7,  3'd0, 32'h0000_0064);
    add_typed(1, 8'hA5, 10'd3,    3'd6, 32'd101,        MOT_CMD,  7'd0,  0, 3'd0, 8'hA5,
              MODE_RUN);
    add_typed(0, 8'h00, 10'd4,    3'd6, 32'hFFFF_FFFF,  MOT_STOP, 7'd0,  0, 3'd0, 8'h00,
              MODE_TURN);
    add_typed(1, 8'h5A, 10'd1023, 3'd4, 32'd0,          MOT_CMD,  7'd0,  0, 3'd0, 8'h5A,
              MODE_RUN);
    add_typed(0, 8'h00, 10'd1023, 3'd0, 32'd300,        MOT_LINE, 7'd70, 1, 3'd0, 8'h00,
              MODE_RUN);
    add_typed(0, 8'h00, 10'd15,   3'd5, 32'd301,        MOT_LINE, 7'd70, 1, 3'd5, 8'h00,
              MODE_RUN);
    add_typed(0, 8'h00, 10'd512,  3'd3, 32'h8000_0000,  MOT_LINE, 7'd70, 1, 3'd3, 8'h00,
              MODE_RUN);
  endfunction

  // Random tick: time mostly creeps forward, distances cluster around the thresholds.
  function automatic tick_t random_tick();
    tick_t             t;
    logic [DIST_W-1:0] near_cm;
    int unsigned       pick;
    pick = $urandom_range(99);
    if (pick < 60) clock_now += $urandom_range(80);
    else if (pick < 90) clock_now += $urandom_range(320, 150);
    else if (pick < 95) clock_now += $urandom;
    else clock_now = $urandom;
    t.stamp     = clock_now;
    t.cmd_valid = ($urandom_range(99) < 6);
    t.cmd       = CMD_W'($urandom);
    t.line      = LINE_W'($urandom);
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        case ($urandom_range(3))
          0:       near_cm = limits.danger_cm;
          1:       near_cm = limits.back_cm;
          2:       near_cm = limits.slow_cm;
          default: near_cm = limits.safe_cm;
        endcase
        t.dist_cm = DIST_W'(near_cm + $urandom_range(4) - 2);
      end
      4, 5:    t.dist_cm = DIST_W'($urandom);
      6:       t.dist_cm = $urandom_range(1) ? '1 : '0;
      default: t.dist_cm = DIST_W'(limits.safe_cm + $urandom_range(40));
    endcase
    return t;
  endfunction

  // Offer one tick, hold it until accepted, then queue the decision it must produce.
  task automatic send_tick(input tick_t t, input bit typed, input drive_t typed_want);
    drive_t shadow;
    while (gap_pct != 0 && !calm && $urandom_range(99) < gap_pct) begin
      tick_if.valid         <= 1'b0;
      tick_if.command_valid <= 1'($urandom);
      tick_if.distance_cm   <= DIST_W'($urandom);
      tick_if.now_tick      <= $urandom;
      @(posedge clk_i);
    end
    tick_if.valid         <= 1'b1;
    tick_if.command_valid <= t.cmd_valid;
    tick_if.command       <= t.cmd;
    tick_if.distance_cm   <= t.dist_cm;
    tick_if.line_bits     <= t.line;
    tick_if.now_tick      <= t.stamp;
    @(posedge clk_i);
    while (!tick_if.ready) @(posedge clk_i);
    shadow = predict_drive(t);
    pending_drive_q.push_back(typed ? typed_want : shadow);
  endtask

  // Drop valid and let every outstanding decision come out.
  task automatic drain_results();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_drive_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
    limit_if.valid <= 1'b1;
    limit_if.index <= idx;
    limit_if.data  <= val;
    @(posedge clk_i);
    while (!limit_if.ready) @(posedge clk_i);
    case (idx)
      CFG_DANGER_CM:    limits.danger_cm    = val;
      CFG_BACK_CM:      limits.back_cm      = val;
      CFG_SLOW_CM:      limits.slow_cm      = val;
      CFG_SAFE_CM:      limits.safe_cm      = val;
      CFG_CRUISE_SPEED: limits.cruise_speed = val[SPEED_W-1:0];
      CFG_SLOW_SPEED:   limits.slow_speed   = val[SPEED_W-1:0];
      CFG_BACK_SPEED:   limits.back_speed   = val[SPEED_W-1:0];
      CFG_TURN_SPEED:   limits.turn_speed   = val[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite all eight registers, then poke one unmapped index that must be dropped.
  task automatic program_limits(input limits_kind_e kind);
    logic [CFG_DATA_W-1:0] v [LIMIT_COUNT];
    int                    i;
    for (i = 0; i < LIMIT_COUNT; i++) begin
      case (kind)
        LIM_ALL_LOW:  v[i] = '0;
        LIM_ALL_HIGH: v[i] = '1;
        default:      v[i] = CFG_DATA_W'($urandom);
      endcase
    end
    if (kind == LIM_ORDERED) begin
      v[CFG_DANGER_CM] = CFG_DATA_W'($urandom_range(40));
      v[CFG_BACK_CM]   = CFG_DATA_W'(v[CFG_DANGER_CM] + $urandom_range(20));
      v[CFG_SLOW_CM]   = CFG_DATA_W'(v[CFG_BACK_CM] + $urandom_range(30));
      v[CFG_SAFE_CM]   = CFG_DATA_W'(v[CFG_SLOW_CM] + $urandom_range(40));
    end
    for (i = 0; i < LIMIT_COUNT; i++) write_limit(CFG_IDX_W'(i), v[i]);
    write_limit(CFG_IDX_W'(LIMIT_COUNT + $urandom_range(2**CFG_IDX_W - 1 - LIMIT_COUNT)),
                CFG_DATA_W'($urandom));
    limit_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      failed = 1'b1;
    end
  endtask

  // Receiver: stall at the phase's rate, or not at all while calm.
  always @(posedge clk_i) begin
    if (calm || stall_pct == 0) drive_if.ready <= 1'b1;
    else drive_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Compare every accepted decision with the oldest one still owed.
  always @(posedge clk_i) begin : watch_results
    drive_t want;
    if (rst_ni && drive_if.valid && drive_if.ready) begin
      if (pending_drive_q.size() == 0) begin
        $error("unexpected result item: motion %0d mode %0d", drive_if.motion,
               drive_if.mode_out);
        failed = 1'b1;
      end else begin
        want = pending_drive_q.pop_front();
        check_field("motion",      32'(want.motion),    32'(drive_if.motion));
        check_field("speed",       32'(want.speed),     32'(drive_if.speed));
        check_field("speed_set",   32'(want.speed_set), 32'(drive_if.speed_set));
        check_field("line_out",    32'(want.line_out),  32'(drive_if.line_out));
        check_field("command_out", 32'(want.cmd_out),   32'(drive_if.command_out));
        check_field("mode_out",    32'(want.mode),      32'(drive_if.mode_out));
      end
    end
  end

  initial begin : stimulus
    limits_kind_e kind;
    drive_t       filler;
    int           n;
    int           p;
    int           k;
    rst_ni                = 1'b0;
    tick_if.valid         = 1'b0;
    tick_if.command_valid = 1'b0;
    tick_if.command       = '0;
    tick_if.distance_cm   = '0;
    tick_if.line_bits     = '0;
    tick_if.now_tick      = '0;
    limit_if.valid        = 1'b0;
    limit_if.index        = '0;
    limit_if.data         = '0;
    gap_pct               = 0;
    stall_pct             = 0;
    calm                  = 1'b0;

    // Shadow starts from the reset state of the block.
    limits.danger_cm    = 5;
    limits.back_cm      = 7;
    limits.slow_cm      = 15;
    limits.safe_cm      = 30;
    limits.cruise_speed = 70;
    limits.slow_speed   = 40;
    limits.back_speed   = 50;
    limits.turn_speed   = 60;
    drive_mode          = MODE_RUN;
    entered_at          = '0;
    spin_cw             = 1'b0;
    filler.motion       = MOT_NONE;
    filler.mode         = MODE_RUN;
    build_directed();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed walk, back to back, no stalls.
    for (n = 0; n < directed_q.size(); n++) send_tick(directed_q[n], typed_q[n], typed_want_q[n]);

    // Random phases: each starts idle, reloads the limits and picks an idling pattern.
    clock_now = 32'hFFFF_F000;
    for (p = 0; p < PHASE_COUNT; p++) begin
      drain_results();
      case (p)
        1:       kind = LIM_ALL_LOW;
        3:       kind = LIM_ALL_HIGH;
        5:       kind = LIM_SCRAMBLED;
        default: kind = LIM_ORDERED;
      endcase
      program_limits(kind);
      case (p % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 72; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 72; end
        default: begin gap_pct = 15; stall_pct = 15; end
      endcase
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // Insert calm stretches with no idling on either side now and then.
        if (k % 20 == 0) calm = ($urandom_range(2) == 0);
        // Hold off the sender until the block has fully emptied.
        if ($urandom_range(59) == 0) drain_results();
        send_tick(random_tick(), 1'b0, filler);
      end
    end

    drain_results();
    if (!failed) begin
      $display("obstacle_avoid_drive_fsm: match");
    end else begin
      $display("obstacle_avoid_drive_fsm: mismatch");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("obstacle_avoid_drive_fsm: mismatch");
    $finish;
  end

endmodule

### filelist.f
src/odf_pkg.sv
src/odf_if.sv
src/odf_cfg_regs.sv
src/obstacle_avoid_drive_fsm.sv
src/odf_checker.sv
tb/tb_obstacle_avoid_drive_fsm.sv
